[rtl/bitmap_priority_ready_queue_macros.svh]
// Assertion macros used by the ready queue level controller.
`ifndef BITMAP_PRIORITY_READY_QUEUE_MACROS_SVH
`define BITMAP_PRIORITY_READY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define BRQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("brq assertion failed");
// Consequent checked at the clock edge after the antecedent holds.
`define BRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brq assertion failed");
`else
`define BRQ_ASSERT(lbl, clk, rst, prop)
`define BRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/brq_pkg.sv]
// Package with sizes, status codes and shared types of the ready queue.
package brq_pkg;

  localparam int LEVELS      = 32;
  localparam int LEVEL_DEPTH = 16;
  localparam int ENTRIES     = LEVELS * LEVEL_DEPTH;

  localparam int LVL_W    = $clog2(LEVELS);
  localparam int PTR_W    = $clog2(LEVEL_DEPTH);
  localparam int FILL_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam int OP_W     = 1;
  localparam int PID_W    = 8;
  localparam int PRIO_W   = 5;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int READY_W  = 10;
  localparam int BITMAP_W = 32;
  localparam int ENTRY_W  = PID_W + TIME_W;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 1'b0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PID_W-1:0]  process_id;
    logic [PRIO_W-1:0] priority_level;
    logic [TIME_W-1:0] enter_time;
  } brq_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                deq_ok;
    logic [READY_W-1:0]  ready_count;
    logic [BITMAP_W-1:0] level_bitmap;
  } brq_res_t;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } brq_mem_req_t;

endpackage

[rtl/brq_if.sv]
// Command and response stream interfaces of the ready queue.
interface brq_in_if;
  import brq_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PID_W-1:0]  process_id;
  logic [PRIO_W-1:0] priority_level;
  logic [TIME_W-1:0] enter_time;

  modport source (output valid, output opcode, output process_id,
                  output priority_level, output enter_time, input ready);
  modport sink (input valid, input opcode, input process_id,
                input priority_level, input enter_time, output ready);
endinterface

interface brq_out_if;
  import brq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PID_W-1:0]    out_process_id;
  logic [TIME_W-1:0]   out_enter_time;
  logic [READY_W-1:0]  ready_count;
  logic [BITMAP_W-1:0] level_bitmap;

  modport source (output valid, output status, output out_process_id,
                  output out_enter_time, output ready_count,
                  output level_bitmap, input ready);
  modport sink (input valid, input status, input out_process_id,
                input out_enter_time, input ready_count,
                input level_bitmap, output ready);
endinterface

[rtl/brq_ram.sv]
// Generic single-port RAM with registered read.
module brq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/brq_level_ctrl.sv]
// Per-level FIFO pointers, fill counts, non-empty bitmap and total count.
`include "bitmap_priority_ready_queue_macros.svh"

module brq_level_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  brq_pkg::brq_cmd_t     cmd,
  output brq_pkg::brq_res_t     res,
  output brq_pkg::brq_mem_req_t mem
);
  import brq_pkg::*;

  logic [PTR_W-1:0]  head [LEVELS];
  logic [PTR_W-1:0]  tail [LEVELS];
  logic [FILL_W-1:0] fill [LEVELS];
  logic [LEVELS-1:0] bitmap;
  logic [CNT_W-1:0]  count;

  logic [LEVELS-1:0] bitmap_next;
  logic [CNT_W-1:0]  count_next;

  logic              lvl_ok;
  logic              found;
  logic [LVL_W-1:0]  enq_idx;
  logic [LVL_W-1:0]  enc_idx;
  logic [LVL_W-1:0]  sel_idx;
  logic [FILL_W-1:0] sel_fill;
  logic [PTR_W-1:0]  sel_head;
  logic [PTR_W-1:0]  sel_tail;
  logic              enq_go;
  logic              deq_go;
  logic [LEVELS-1:0] fill_nz;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // Lowest set bit wins: scan from the top so the lowest index lands last.
  always_comb begin
    enc_idx = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (bitmap[i]) begin
        enc_idx = LVL_W'(i);
      end
    end
  end

  always_comb begin
    found    = |bitmap;
    lvl_ok   = 32'(cmd.priority_level) < LEVELS;
    enq_idx  = cmd.priority_level[LVL_W-1:0];
    sel_idx  = (cmd.opcode == OP_DEQUEUE) ? enc_idx : enq_idx;
    sel_fill = fill[sel_idx];
    sel_head = head[sel_idx];
    sel_tail = tail[sel_idx];
    enq_go   = (cmd.opcode == OP_ENQUEUE) && lvl_ok &&
               (sel_fill != FILL_W'(LEVEL_DEPTH));
    deq_go   = (cmd.opcode == OP_DEQUEUE) && found && (sel_fill != '0);

    bitmap_next = bitmap;
    count_next  = count;
    if (take && enq_go) begin
      bitmap_next[sel_idx] = 1'b1;
      count_next           = CNT_W'(count + 1'b1);
    end else if (take && deq_go) begin
      if (sel_fill == FILL_W'(1)) begin
        bitmap_next[sel_idx] = 1'b0;
      end
      if (count != '0) begin
        count_next = CNT_W'(count - 1'b1);
      end
    end

    if (cmd.opcode == OP_DEQUEUE) begin
      res.status = deq_go ? STATUS_OK : STATUS_EMPTY;
    end else begin
      res.status = enq_go ? STATUS_OK : STATUS_FULL;
    end
    res.deq_ok       = deq_go;
    res.ready_count  = READY_W'(count_next);
    res.level_bitmap = BITMAP_W'(bitmap_next);

    mem.wr_en = take && enq_go;
    mem.rd_en = take && deq_go;
    mem.addr  = ADDR_W'(ADDR_W'(sel_idx) * ADDR_W'(LEVEL_DEPTH)) +
                ADDR_W'((cmd.opcode == OP_DEQUEUE) ? sel_head : sel_tail);
    mem.wdata = {cmd.process_id, cmd.enter_time};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
      bitmap <= '0;
      count  <= '0;
    end else begin
      if (take && enq_go) begin
        tail[sel_idx] <= wrap_inc(sel_tail);
        fill[sel_idx] <= FILL_W'(sel_fill + 1'b1);
      end else if (take && deq_go) begin
        head[sel_idx] <= wrap_inc(sel_head);
        fill[sel_idx] <= FILL_W'(sel_fill - 1'b1);
      end
      bitmap <= bitmap_next;
      count  <= count_next;
    end
  end

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      fill_nz[i] = (fill[i] != '0);
    end
  end

  `BRQ_ASSERT(a_bitmap_tracks_fill, clk, rst, bitmap == fill_nz)
  `BRQ_ASSERT(a_empty_count_no_bits, clk, rst, (count != '0) || (bitmap == '0))
  `BRQ_ASSERT_NEXT(a_enq_sets_bit, clk, rst, take && enq_go, bitmap[$past(enq_idx)])
  `BRQ_ASSERT_NEXT(a_deq_counts_down, clk, rst, take && deq_go, count == $past(count) - 1'b1)

endmodule

[rtl/bitmap_priority_ready_queue.sv]
// Top level of the bitmap priority ready queue.
//
//   channel  role    dir  payload
//   cmd      sink    in   opcode, process_id, priority_level, enter_time
//   rsp      source  out  status, out_process_id, out_enter_time, ready_count,
//                         level_bitmap
//
// One transaction per cycle is taken unless cmd stalls; the accept edge updates the level
// pointers and reads the entry RAM; the middle stage then loads the output register.
// The next command sees the updated pointers, fill counts and bitmap at once.
// Reset clears all level state; the entry RAM needs no clearing.
// A stalled rsp holds the output register; cmd stalls only during reset or while the middle stage
// and the output register are both full and rsp.ready is low.
module bitmap_priority_ready_queue (
  input logic      clk,
  input logic      rst,
  brq_in_if.sink   cmd,
  brq_out_if.source rsp
);
  import brq_pkg::*;

  brq_cmd_t     cmd_s;
  brq_res_t     res;
  brq_mem_req_t mem_req;
  logic [ENTRY_W-1:0] rdata;

  logic     take;
  logic     s1_valid;
  brq_res_t s1_res;
  logic     s1_adv;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [PID_W-1:0]    out_pid;
  logic [TIME_W-1:0]   out_time;
  logic [READY_W-1:0]  out_count;
  logic [BITMAP_W-1:0] out_bitmap;

  assign cmd_s.opcode         = cmd.opcode;
  assign cmd_s.process_id     = cmd.process_id;
  assign cmd_s.priority_level = cmd.priority_level;
  assign cmd_s.enter_time     = cmd.enter_time;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !rst && (!s1_valid || s1_adv);
  assign take      = cmd.valid && cmd.ready;

  brq_level_ctrl u_level_ctrl (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .cmd  (cmd_s),
    .res  (res),
    .mem  (mem_req)
  );

  brq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .wr_en (mem_req.wr_en),
    .rd_en (mem_req.rd_en),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: RAM data is valid while the middle stage holds a dequeue.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_res <= res;
    end
    if (s1_adv) begin
      out_status <= s1_res.status;
      out_pid    <= s1_res.deq_ok ? rdata[ENTRY_W-1:TIME_W] : '0;
      out_time   <= s1_res.deq_ok ? rdata[TIME_W-1:0] : '0;
      out_count  <= s1_res.ready_count;
      out_bitmap <= s1_res.level_bitmap;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.out_process_id = out_pid;
  assign rsp.out_enter_time = out_time;
  assign rsp.ready_count    = out_count;
  assign rsp.level_bitmap   = out_bitmap;

endmodule
